// ----- hdl/fba_pkg.sv -----
// fba_pkg: shared constants, types and helpers for the frame bitmap allocator.
// No dependencies.
package fba_pkg;

	localparam int NUM_FRAMES = 4096;
	localparam int WORD_W     = 32;
	localparam int NUM_WORDS  = NUM_FRAMES / WORD_W;
	localparam int WADDR_W    = $clog2(NUM_WORDS);
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int FRAME_W    = 12;
	localparam int STATUS_W   = 3;

	localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MAPPED    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FREED     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOTHING   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [WORD_W-1:0]  FULL_WORD = '1;
	localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [WADDR_W-1:0] waddr_t;

	// write beat into the bitmap store
	typedef struct packed {
		logic   en;
		waddr_t addr;
		word_t  data;
	} fba_wr_t;

	// index of the lowest clear bit; only meaningful when the word is not full
	function automatic logic [BIT_W-1:0] lowest_zero(input word_t w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!w[i]) idx = BIT_W'(i);
		end
		return idx;
	endfunction

endpackage

// ----- hdl/fba_bitmap_ram.sv -----
// fba_bitmap_ram: one-read one-write bitmap store, registered read, per-word valid bits.
// Depends on fba_pkg. A word never written reads as zero (frame free).
module fba_bitmap_ram (
	input  logic            clk,
	input  logic            arst_n,
	input  fba_pkg::waddr_t raddr,
	output fba_pkg::word_t  rdata,
	input  fba_pkg::fba_wr_t wr
);

	fba_pkg::word_t mem [fba_pkg::NUM_WORDS];
	logic [fba_pkg::NUM_WORDS-1:0] valid_q;
	fba_pkg::word_t rd_q;
	logic           rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.addr] <= wr.data;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) valid_q[wr.addr] <= 1'b1;
			rd_valid_q <= valid_q[raddr];
		end
	end

	assign rdata = rd_valid_q ? rd_q : '0;

endmodule

// ----- hdl/frame_bitmap_allocator_unit.sv -----
// frame_bitmap_allocator_unit: first-fit page frame allocator over a bitmap store.
// Depends on fba_pkg and fba_bitmap_ram.
//
//  channel  | handshake         | fields
//  ---------+-------------------+----------------------------------------------
//  request  | start / busy      | kind, current_frame, kernel_page, page_rw
//  result   | done (one cycle)  | status, new_frame, present, writable, user_mode
//
// Already-mapped and nothing-to-free requests answer in the cycle after the beat.
// A free answers after it steps through issue, read word and write back.
// An allocate scans one bitmap word per cycle from word 0 and answers once a word
// holds a free frame, or after the last word when every frame is used.
// Reset clears the per-word valid bits at once; no clearing pass is needed.
// The result cannot be stalled; busy is low in the cycle done is shown.
module frame_bitmap_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [fba_pkg::FRAME_W-1:0]   current_frame,
	input  logic                          kernel_page,
	input  logic                          page_rw,
	output logic                          done,
	output logic [fba_pkg::STATUS_W-1:0]  status,
	output logic [fba_pkg::FRAME_W-1:0]   new_frame,
	output logic                          present,
	output logic                          writable,
	output logic                          user_mode
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ISSUE = 2'd1;
	localparam logic [1:0] S_CHECK = 2'd2;

	logic [1:0] state_q;

	logic                        kind_q, kern_q, wr_q;
	logic [fba_pkg::FRAME_W-1:0] cur_q;
	fba_pkg::waddr_t             addr_q;
	fba_pkg::waddr_t             addr_s1;

	fba_pkg::word_t  rdata;
	fba_pkg::fba_wr_t wr;

	logic                         done_q, pres_q, rw_q, usr_q;
	logic [fba_pkg::STATUS_W-1:0] status_q;
	logic [fba_pkg::FRAME_W-1:0]  nf_q;

	logic                   accept;
	logic                   word_full;
	logic [fba_pkg::BIT_W-1:0] zbit;
	logic [fba_pkg::BIT_W-1:0] cur_bit;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign word_full = (rdata == fba_pkg::FULL_WORD);
	assign zbit      = fba_pkg::lowest_zero(rdata);
	assign cur_bit   = cur_q[fba_pkg::BIT_W-1:0];

	fba_bitmap_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (addr_q),
		.rdata  (rdata),
		.wr     (wr)
	);

	// write back in the check cycle: set the found bit, or clear the freed one
	always_comb begin
		wr = '0;
		if (state_q == S_CHECK) begin
			if (kind_q == fba_pkg::KIND_FREE) begin
				wr.en   = 1'b1;
				wr.addr = addr_s1;
				wr.data = rdata & ~(fba_pkg::word_t'(1) << cur_bit);
			end else if (!word_full) begin
				wr.en   = 1'b1;
				wr.addr = addr_s1;
				wr.data = rdata | (fba_pkg::word_t'(1) << zbit);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if ((kind == fba_pkg::KIND_ALLOC && current_frame != '0) ||
						    (kind == fba_pkg::KIND_FREE && current_frame == '0)) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_ISSUE;
						end
					end
				end
				S_ISSUE: state_q <= S_CHECK;
				S_CHECK: begin
					if (kind_q == fba_pkg::KIND_FREE || !word_full ||
					    addr_s1 == fba_pkg::LAST_WORD) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload and scan address
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q <= kind;
					cur_q  <= current_frame;
					kern_q <= kernel_page;
					wr_q   <= page_rw;
					addr_q <= (kind == fba_pkg::KIND_FREE) ?
					          current_frame[fba_pkg::FRAME_W-1:fba_pkg::BIT_W] : '0;
					pres_q <= 1'b0;
					rw_q   <= 1'b0;
					usr_q  <= 1'b0;
					if (kind == fba_pkg::KIND_ALLOC) begin
						status_q <= fba_pkg::ST_MAPPED;
						nf_q     <= current_frame;
					end else begin
						status_q <= fba_pkg::ST_NOTHING;
						nf_q     <= '0;
					end
				end
			end
			S_ISSUE: begin
				addr_s1 <= addr_q;
				addr_q  <= addr_q + 1'b1;
			end
			S_CHECK: begin
				addr_s1 <= addr_q;
				addr_q  <= addr_q + 1'b1;
				pres_q  <= 1'b0;
				rw_q    <= 1'b0;
				usr_q   <= 1'b0;
				nf_q    <= '0;
				if (kind_q == fba_pkg::KIND_FREE) begin
					status_q <= fba_pkg::ST_FREED;
				end else if (!word_full) begin
					status_q <= fba_pkg::ST_ALLOCATED;
					nf_q     <= {addr_s1, zbit};
					pres_q   <= 1'b1;
					rw_q     <= wr_q;
					usr_q    <= ~kern_q;
				end else begin
					status_q <= fba_pkg::ST_EXHAUSTED;
				end
			end
			default: ;
		endcase
	end

	assign done      = done_q;
	assign status    = status_q;
	assign new_frame = nf_q;
	assign present   = pres_q;
	assign writable  = rw_q;
	assign user_mode = usr_q;

endmodule

// ----- hdl/fba_checker.sv -----
// fba_checker: port-level checks for frame_bitmap_allocator_unit, bound to the top level.
// Depends on fba_pkg.
module fba_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          kind,
	input logic [fba_pkg::FRAME_W-1:0]   current_frame,
	input logic                          done,
	input logic [fba_pkg::STATUS_W-1:0]  status,
	input logic [fba_pkg::FRAME_W-1:0]   new_frame,
	input logic                          present,
	input logic                          writable,
	input logic                          user_mode
);

	// mapped page answers on the next cycle and echoes its frame
	a_mapped: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind == fba_pkg::KIND_ALLOC && current_frame != '0
		|=> done && status == fba_pkg::ST_MAPPED && new_frame == $past(current_frame))
		else $error("mapped request not answered at once");

	a_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind == fba_pkg::KIND_FREE && current_frame == '0
		|=> done && status == fba_pkg::ST_NOTHING)
		else $error("empty free not answered at once");

	a_no_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result beat while busy");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != fba_pkg::ST_ALLOCATED && status != fba_pkg::ST_MAPPED
		|-> new_frame == '0 && !present && !writable && !user_mode)
		else $error("nonzero fields on a non-allocating result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status == fba_pkg::ST_ALLOCATED || status == fba_pkg::ST_MAPPED ||
		         status == fba_pkg::ST_FREED || status == fba_pkg::ST_NOTHING ||
		         status == fba_pkg::ST_EXHAUSTED)
		else $error("undefined status code");

endmodule

bind frame_bitmap_allocator_unit fba_checker u_fba_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.kind          (kind),
	.current_frame (current_frame),
	.done          (done),
	.status        (status),
	.new_frame     (new_frame),
	.present       (present),
	.writable      (writable),
	.user_mode     (user_mode)
);

// ----- tb/fba_result_checker.sv -----
// fba_result_checker: watches the request and result channels of the frame bitmap
// allocator, keeps its own copy of the frame bitmap and checks every result beat.
// Depends on fba_pkg.
module fba_result_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          kind,
	input  logic [fba_pkg::FRAME_W-1:0]   current_frame,
	input  logic                          kernel_page,
	input  logic                          page_rw,
	input  logic                          done,
	input  logic [fba_pkg::STATUS_W-1:0]  status,
	input  logic [fba_pkg::FRAME_W-1:0]   new_frame,
	input  logic                          present,
	input  logic                          writable,
	input  logic                          user_mode,
	output int                            errors,
	output int                            pending,
	output int                            checked,
	output int                            allocated,
	output int                            exhausted
);

	// only whole words are scanned
	localparam int SCAN_FRAMES = fba_pkg::NUM_WORDS * fba_pkg::WORD_W;

	typedef logic [fba_pkg::FRAME_W-1:0] frame_t;

	typedef struct packed {
		logic [fba_pkg::STATUS_W-1:0] status;
		frame_t                       frame;
		logic                         present;
		logic                         writable;
		logic                         user_mode;
	} page_entry_t;

	logic [SCAN_FRAMES-1:0] frames_in_use;
	page_entry_t            expected_entries[$];
	int                     n_bad;
	int                     n_checked;
	int                     n_alloc;
	int                     n_out;

	// next page entry for one request; updates the bitmap copy
	function automatic page_entry_t predict_page_entry(input logic req_kind,
			input frame_t cur, input logic kern, input logic wr);
		page_entry_t e;
		int          f;
		e = '0;
		f = -1;
		if (req_kind == fba_pkg::KIND_ALLOC) begin
			if (cur != '0) begin
				e.status = fba_pkg::ST_MAPPED;
				e.frame  = cur;
			end else begin
				for (int i = SCAN_FRAMES - 1; i >= 0; i--)
					if (!frames_in_use[i]) f = i;
				if (f < 0) begin
					e.status = fba_pkg::ST_EXHAUSTED;
				end else begin
					frames_in_use[f] = 1'b1;
					e.status    = fba_pkg::ST_ALLOCATED;
					e.frame     = frame_t'(f);
					e.present   = 1'b1;
					e.writable  = wr;
					e.user_mode = ~kern;
				end
			end
		end else if (cur == '0) begin
			e.status = fba_pkg::ST_NOTHING;
		end else begin
			if (int'(cur) < SCAN_FRAMES) frames_in_use[cur] = 1'b0;
			e.status = fba_pkg::ST_FREED;
		end
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		page_entry_t got;
		page_entry_t want;
		if (!arst_n) begin
			frames_in_use = '0;
			expected_entries.delete();
			n_bad     = 0;
			n_checked = 0;
			n_alloc   = 0;
			n_out     = 0;
		end else begin
			// result first: a new beat may be taken at the edge that ends a result
			if (done) begin
				got = {status, new_frame, present, writable, user_mode};
				n_checked++;
				if (status == fba_pkg::ST_EXHAUSTED) n_out++;
				if (expected_entries.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("%0t: result with no request waiting: status %0d frame %0d",
							$time, status, new_frame);
				end else begin
					want = expected_entries.pop_front();
					if (want.status == fba_pkg::ST_ALLOCATED) n_alloc++;
					if (got !== want) begin
						n_bad++;
						if (n_bad <= 10)
							$display("%0t: exp/got status %0d/%0d frame %0d/%0d pwu %b%b%b/%b%b%b",
								$time, want.status, got.status, want.frame, got.frame,
								want.present, want.writable, want.user_mode,
								got.present, got.writable, got.user_mode);
					end
				end
			end
			if (start && !busy)
				expected_entries.push_back(
					predict_page_entry(kind, current_frame, kernel_page, page_rw));
		end
		errors    <= n_bad;
		pending   <= expected_entries.size();
		checked   <= n_checked;
		allocated <= n_alloc;
		exhausted <= n_out;
	end

endmodule

// ----- tb/tb.sv -----
// tb: stimulus and verdict for frame_bitmap_allocator_unit; result checking lives in
// fba_result_checker, instantiated beside the block. Depends on fba_pkg.
module tb;

	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int DRAIN_CYCLES = 140;
	localparam int RANDOM_ITEMS = 1380;
	localparam int TAIL_ITEMS   = 200;

	typedef logic [fba_pkg::FRAME_W-1:0] frame_t;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic                         kind;
	frame_t                       current_frame;
	logic                         kernel_page;
	logic                         page_rw;
	logic                         done;
	logic [fba_pkg::STATUS_W-1:0] status;
	frame_t                       new_frame;
	logic                         present;
	logic                         writable;
	logic                         user_mode;

	int errors;
	int pending;
	int checked;
	int allocated;
	int exhausted;
	int cycle_count = 0;
	bit no_idle;

	// frames seen handed out and not yet given back by this side
	frame_t live_frames[$];

	frame_bitmap_allocator_unit u_top (.*);
	fba_result_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		if (done && status == fba_pkg::ST_ALLOCATED) live_frames.push_back(new_frame);

	// wait out busy, then, unless no_idle is set, idle each cycle with an 18 percent chance before the beat
	task automatic issue(input logic k, input frame_t cur,
			input logic kern, input logic wr);
		@(negedge clk);
		while (busy) @(negedge clk);
		while (!no_idle && $urandom_range(99) < 18) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start         <= 1'b1;
		kind          <= k;
		current_frame <= cur;
		kernel_page   <= kern;
		page_rw       <= wr;
		do @(posedge clk); while (busy);
	endtask

	task automatic random_request();
		int     r;
		int     idx;
		frame_t f;
		r = $urandom_range(99);
		if (r < 50) begin
			issue(fba_pkg::KIND_ALLOC, '0, 1'($urandom_range(1)), 1'($urandom_range(1)));
		end else if (r < 62) begin
			issue(fba_pkg::KIND_ALLOC, frame_t'($urandom_range(4095, 1)),
				1'($urandom_range(1)), 1'($urandom_range(1)));
		end else if (r < 90 && live_frames.size() > 0) begin
			idx = $urandom_range(live_frames.size() - 1);
			f   = live_frames[idx];
			live_frames.delete(idx);
			issue(fba_pkg::KIND_FREE, f, 1'($urandom_range(1)), 1'($urandom_range(1)));
		end else if (r < 96) begin
			issue(fba_pkg::KIND_FREE, frame_t'($urandom_range(4095)),
				1'($urandom_range(1)), 1'($urandom_range(1)));
		end else begin
			issue(fba_pkg::KIND_FREE, '0, 1'($urandom_range(1)), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		kind          = fba_pkg::KIND_ALLOC;
		current_frame = '0;
		kernel_page   = 1'b0;
		page_rw       = 1'b0;
		no_idle       = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: frame zero first, all flag pairs, holes, mapped and empty frees
		issue(fba_pkg::KIND_ALLOC, '0, 1'b0, 1'b0);
		issue(fba_pkg::KIND_ALLOC, '0, 1'b1, 1'b1);
		issue(fba_pkg::KIND_ALLOC, '0, 1'b0, 1'b1);
		issue(fba_pkg::KIND_ALLOC, '0, 1'b1, 1'b0);
		issue(fba_pkg::KIND_ALLOC, 12'hFFF, 1'b1, 1'b1);
		issue(fba_pkg::KIND_ALLOC, 12'h001, 1'b0, 1'b0);
		issue(fba_pkg::KIND_ALLOC, 12'hAAA, 1'b0, 1'b1);
		issue(fba_pkg::KIND_ALLOC, 12'h555, 1'b1, 1'b0);
		issue(fba_pkg::KIND_FREE, '0, 1'b1, 1'b1);
		issue(fba_pkg::KIND_FREE, '0, 1'b0, 1'b0);
		issue(fba_pkg::KIND_FREE, 12'h002, 1'b0, 1'b0);
		issue(fba_pkg::KIND_FREE, 12'hFFF, 1'b1, 1'b1);
		issue(fba_pkg::KIND_ALLOC, '0, 1'b0, 1'b0);
		issue(fba_pkg::KIND_FREE, 12'h001, 1'b1, 1'b0);
		issue(fba_pkg::KIND_FREE, 12'h003, 1'b0, 1'b1);
		issue(fba_pkg::KIND_ALLOC, '0, 1'b1, 1'b1);
		issue(fba_pkg::KIND_ALLOC, '0, 1'b0, 1'b1);
		issue(fba_pkg::KIND_ALLOC, '0, 1'b1, 1'b0);
		issue(fba_pkg::KIND_FREE, 12'h800, 1'b0, 1'b0);
		issue(fba_pkg::KIND_FREE, 12'h7FF, 1'b1, 1'b1);
		issue(fba_pkg::KIND_FREE, 12'h004, 1'b0, 1'b0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			no_idle = (i >= 700 && i < 1000);
			random_request();
		end
		no_idle = 1'b0;

		// give back a batch of live frames in random order, then mix again
		for (int i = 0; i < 48 && live_frames.size() > 0; i++) begin
			live_frames.shuffle();
			issue(fba_pkg::KIND_FREE, live_frames.pop_front(), 1'($urandom_range(1)),
				1'($urandom_range(1)));
		end
		for (int i = 0; i < TAIL_ITEMS; i++)
			random_request();

		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d results checked: %0d frames handed out, %0d out-of-frames answers",
			checked, allocated, exhausted);
		$display("directed corners, random mix with idle gaps and a gapless stretch, %0d live",
			live_frames.size());
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- frame_bitmap_allocator_unit.f -----
hdl/fba_pkg.sv
hdl/fba_bitmap_ram.sv
hdl/frame_bitmap_allocator_unit.sv
hdl/fba_checker.sv
tb/fba_result_checker.sv
tb/tb.sv
